>>> rtl/core/fco_pkg.sv
// Shared types and constants of the fly camera orientation unit.
// No dependencies.
`default_nettype none
package fco_pkg;
    localparam logic REQ_ROTATE = 1'b0;
    localparam logic REQ_MOVE   = 1'b1;
    localparam logic [2:0] CFG_SENS  = 3'd0;
    localparam logic [2:0] CFG_SPEED = 3'd1;
    localparam logic [2:0] CFG_EYE_X = 3'd2;
    localparam logic [2:0] CFG_EYE_Y = 3'd3;
    localparam logic [2:0] CFG_EYE_Z = 3'd4;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int ATAN_N = 20;
    localparam int DEG16_90 = 90 * 65536;

    function automatic logic signed [23:0] atan_deg16(input logic [4:0] i);
        case (i)
            5'd0: atan_deg16 = 24'sd2949120;
            5'd1: atan_deg16 = 24'sd1740967;
            5'd2: atan_deg16 = 24'sd919879;
            5'd3: atan_deg16 = 24'sd466945;
            5'd4: atan_deg16 = 24'sd234379;
            5'd5: atan_deg16 = 24'sd117304;
            5'd6: atan_deg16 = 24'sd58666;
            5'd7: atan_deg16 = 24'sd29335;
            5'd8: atan_deg16 = 24'sd14668;
            5'd9: atan_deg16 = 24'sd7334;
            5'd10: atan_deg16 = 24'sd3667;
            5'd11: atan_deg16 = 24'sd1833;
            5'd12: atan_deg16 = 24'sd917;
            5'd13: atan_deg16 = 24'sd458;
            5'd14: atan_deg16 = 24'sd229;
            5'd15: atan_deg16 = 24'sd115;
            5'd16: atan_deg16 = 24'sd57;
            5'd17: atan_deg16 = 24'sd29;
            5'd18: atan_deg16 = 24'sd14;
            5'd19: atan_deg16 = 24'sd7;
            default: atan_deg16 = 24'sd0;
        endcase
    endfunction

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ANGLE,
        OP_YAW_WRAP,
        OP_TRIG_YAW_START,
        OP_TRIG_PITCH_START,
        OP_TRIG_STEP,
        OP_TRIG_YAW_DONE,
        OP_TRIG_PITCH_DONE,
        OP_FRONT,
        OP_STEP,
        OP_MOVE,
        OP_VIEW
    } op_t;

    typedef struct packed {
        op_t      op;
        logic [2:0] flag_idx;
        logic [1:0] axis;
    } cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/fco_datapath.sv
// Datapath of the fly camera orientation unit: angle state, CORDIC, move and view.
// Depends on fco_pkg.
`default_nettype none
module fco_datapath #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int TRIG_ITERATIONS = 14
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fco_pkg::cmd_t        cmd,
    input  wire logic                 in_type,
    input  wire logic signed [15:0]   in_dx,
    input  wire logic signed [15:0]   in_dy,
    input  wire logic [15:0]          in_delta,
    input  wire logic [9:0]           sens,
    input  wire logic [15:0]          speed,
    input  wire logic signed [31:0]   eye_x,
    input  wire logic signed [31:0]   eye_y,
    input  wire logic signed [31:0]   eye_z,
    output logic                      trig_last,
    output logic                      wrap_last,
    output logic signed [31:0]        view_x,
    output logic signed [31:0]        view_y,
    output logic signed [31:0]        view_z,
    output logic signed [15:0]        front_x,
    output logic signed [15:0]        front_y,
    output logic signed [15:0]        front_z,
    output logic [15:0]               yaw_out,
    output logic signed [14:0]        pitch_out
);
    localparam int SH = 10 - ANGLE_FRAC_BITS;
    localparam int HALF = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int UP = 16 - ANGLE_FRAC_BITS;
    localparam int FULL = 360 << ANGLE_FRAC_BITS;
    localparam int PLIM = (899 << ANGLE_FRAC_BITS) / 10;
    localparam int WRAP_TOP = 7;
    localparam int NIT = (TRIG_ITERATIONS < fco_pkg::ATAN_N) ? TRIG_ITERATIONS
                                                             : fco_pkg::ATAN_N;

    logic [15:0] yaw_reg, yaw_next;
    logic signed [14:0] pitch_reg, pitch_next;
    logic signed [31:0] bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [25:0] cz_reg, cz_next;
    logic neg_reg, neg_next;
    logic [4:0] it_reg, it_next;
    logic signed [27:0] wr_reg, wr_next;
    logic signed [15:0] cyw_reg, cyw_next, syw_reg, syw_next;
    logic signed [15:0] cp_reg, cp_next, sp_reg, sp_next;
    logic signed [15:0] fx_reg, fx_next, fz_reg, fz_next;
    logic [24:0] step_reg, step_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next, vz_reg, vz_next;

    logic signed [27:0] dyaw, dpit;
    logic signed [27:0] ysum, psum;
    logic signed [27:0] wsub, wres;
    logic signed [25:0] ang;
    logic signed [33:0] xr, yr;
    logic signed [15:0] cres, sres;
    logic signed [15:0] fwd_comp, side_comp;
    logic signed [15:0] comp;
    logic addm;
    logic signed [31:0] pos;
    logic signed [42:0] prod;
    logic signed [33:0] dsp, npos;
    logic signed [31:0] mres;
    logic signed [32:0] rprod;

    function automatic logic signed [15:0] clamp14(input logic signed [33:0] v);
        if (v > 34'sd16384) clamp14 = 16'sd16384;
        else if (v < -34'sd16384) clamp14 = -16'sd16384;
        else clamp14 = v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
        else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    always_comb
    begin
        dyaw = (28'(in_dx) * 28'($signed({1'b0, sens})) + 28'(HALF)) >>> SH;
        dpit = (28'(in_dy) * 28'($signed({1'b0, sens})) + 28'(HALF)) >>> SH;
        ysum = 28'($signed({1'b0, yaw_reg})) + dyaw;
        psum = 28'(pitch_reg) + dpit;
        if (psum > 28'(PLIM)) psum = 28'(PLIM);
        if (psum < -28'(PLIM)) psum = -28'(PLIM);

        wsub = 28'(FULL) <<< (3'(WRAP_TOP) - it_reg[2:0]);
        wres = (wr_reg >= wsub) ? wr_reg - wsub : wr_reg;

        xr = (cx_reg + 34'sd32768) >>> 16;
        yr = (cy_reg + 34'sd32768) >>> 16;
        if (neg_reg)
        begin
            xr = -xr;
            yr = -yr;
        end
        cres = clamp14(xr);
        sres = clamp14(yr);

        fwd_comp = (cmd.axis == 2'd0) ? fx_reg : (cmd.axis == 2'd1) ? sp_reg : fz_reg;
        side_comp = (cmd.axis == 2'd0) ? -syw_reg : cyw_reg;
        case (cmd.flag_idx)
            3'd0, 3'd1: comp = fwd_comp;
            3'd2, 3'd3: comp = side_comp;
            default: comp = fco_pkg::ONE_Q14;
        endcase
        addm = (cmd.flag_idx == 3'd0) || (cmd.flag_idx == 3'd3) || (cmd.flag_idx == 3'd4);
        case (cmd.axis)
            2'd0: pos = bx_reg;
            2'd1: pos = by_reg;
            default: pos = bz_reg;
        endcase
        prod = 43'($signed({1'b0, step_reg})) * 43'(comp);
        dsp = 34'((prod + 43'sd8192) >>> 14);
        npos = addm ? 34'(pos) + dsp : 34'(pos) - dsp;
        mres = sat32(npos);
        rprod = 33'(cyw_reg) * 33'(cp_reg);
    end

    always_comb
    begin
        yaw_next = yaw_reg;
        pitch_next = pitch_reg;
        bx_next = bx_reg; by_next = by_reg; bz_next = bz_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        neg_next = neg_reg; it_next = it_reg; wr_next = wr_reg;
        cyw_next = cyw_reg; syw_next = syw_reg; cp_next = cp_reg; sp_next = sp_reg;
        fx_next = fx_reg; fz_next = fz_reg; step_next = step_reg;
        vx_next = vx_reg; vy_next = vy_reg; vz_next = vz_reg;
        ang = '0;
        case (cmd.op)
            fco_pkg::OP_ANGLE:
            begin
                if (in_type == fco_pkg::REQ_ROTATE)
                begin
                    wr_next = ysum + (28'(FULL) <<< WRAP_TOP);
                    pitch_next = psum[14:0];
                end
                else
                    wr_next = 28'($signed({1'b0, yaw_reg})) + (28'(FULL) <<< WRAP_TOP);
                it_next = '0;
            end
            fco_pkg::OP_YAW_WRAP:
            begin
                wr_next = wres;
                it_next = it_reg + 5'd1;
                if (it_reg == 5'(WRAP_TOP))
                    yaw_next = wres[15:0];
            end
            fco_pkg::OP_TRIG_YAW_START, fco_pkg::OP_TRIG_PITCH_START:
            begin
                if (cmd.op == fco_pkg::OP_TRIG_YAW_START)
                begin
                    ang = 26'($signed({1'b0, yaw_reg})) <<< UP;
                    if (ang > 26'sd11796480) ang = ang - 26'sd23592960;
                end
                else
                    ang = 26'(pitch_reg) <<< UP;
                neg_next = 1'b0;
                if (ang > 26'(fco_pkg::DEG16_90))
                begin
                    ang = ang - 26'sd11796480;
                    neg_next = 1'b1;
                end
                else if (ang < -26'(fco_pkg::DEG16_90))
                begin
                    ang = ang + 26'sd11796480;
                    neg_next = 1'b1;
                end
                cx_next = fco_pkg::CORDIC_GAIN;
                cy_next = '0;
                cz_next = ang;
                it_next = '0;
            end
            fco_pkg::OP_TRIG_STEP:
            begin
                if (cz_reg >= 0)
                begin
                    cx_next = cx_reg - (cy_reg >>> it_reg);
                    cy_next = cy_reg + (cx_reg >>> it_reg);
                    cz_next = cz_reg - 26'(fco_pkg::atan_deg16(it_reg));
                end
                else
                begin
                    cx_next = cx_reg + (cy_reg >>> it_reg);
                    cy_next = cy_reg - (cx_reg >>> it_reg);
                    cz_next = cz_reg + 26'(fco_pkg::atan_deg16(it_reg));
                end
                it_next = it_reg + 5'd1;
            end
            fco_pkg::OP_TRIG_YAW_DONE:
            begin
                cyw_next = cres;
                syw_next = sres;
            end
            fco_pkg::OP_TRIG_PITCH_DONE:
            begin
                cp_next = cres;
                sp_next = sres;
                step_next = 25'(({1'b0, 32'(speed) * 32'(in_delta)} + 33'd128) >> 8);
            end
            fco_pkg::OP_FRONT:
            begin
                if (cmd.axis == 2'd0)
                    fx_next = clamp14(34'((rprod + 33'sd8192) >>> 14));
                else
                    fz_next = clamp14(34'((33'(syw_reg) * 33'(cp_reg) + 33'sd8192) >>> 14));
            end
            fco_pkg::OP_MOVE:
            begin
                case (cmd.axis)
                    2'd0: bx_next = mres;
                    2'd1: by_next = mres;
                    default: bz_next = mres;
                endcase
            end
            fco_pkg::OP_VIEW:
            begin
                vx_next = sat32(34'(bx_reg) + 34'(eye_x));
                vy_next = sat32(34'(by_reg) + 34'(eye_y));
                vz_next = sat32(34'(bz_reg) + 34'(eye_z));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg <= '0;
            pitch_reg <= '0;
            bx_reg <= '0; by_reg <= '0; bz_reg <= '0;
        end
        else
        begin
            yaw_reg <= yaw_next;
            pitch_reg <= pitch_next;
            bx_reg <= bx_next; by_reg <= by_next; bz_reg <= bz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
        neg_reg <= neg_next; it_reg <= it_next; wr_reg <= wr_next;
        cyw_reg <= cyw_next; syw_reg <= syw_next; cp_reg <= cp_next; sp_reg <= sp_next;
        fx_reg <= fx_next; fz_reg <= fz_next; step_reg <= step_next;
        vx_reg <= vx_next; vy_reg <= vy_next; vz_reg <= vz_next;
    end

    assign trig_last = (it_reg == 5'(NIT - 1));
    assign wrap_last = (it_reg == 5'(WRAP_TOP));
    assign view_x = vx_reg;
    assign view_y = vy_reg;
    assign view_z = vz_reg;
    assign front_x = fx_reg;
    assign front_y = sp_reg;
    assign front_z = fz_reg;
    assign yaw_out = yaw_reg;
    assign pitch_out = pitch_reg;
endmodule
`default_nettype wire

>>> rtl/core/fco_control.sv
// Sequencer of the fly camera orientation unit: issues datapath commands per request.
// Depends on fco_pkg.
`default_nettype none
module fco_control (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            in_type,
    input  wire logic [5:0]      in_flags,
    input  wire logic            trig_last,
    input  wire logic            wrap_last,
    input  wire logic            out_fire,
    output logic                 busy,
    output logic                 out_valid,
    output fco_pkg::cmd_t        cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_ANGLE, S_WRAP, S_YSTART, S_YRUN, S_YDONE, S_PSTART, S_PRUN, S_PDONE,
        S_FRONT, S_MOVE, S_VIEW, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] flag_reg;
    logic [1:0] axis_reg;
    logic [5:0] flags_reg;
    logic type_reg;
    logic move_hit;

    always_comb
    begin
        move_hit = flags_reg[flag_reg] && !(flag_reg[2] && axis_reg != 2'd1) &&
                   !(flag_reg[2:1] == 2'b01 && axis_reg == 2'd1);
        cmd.op = fco_pkg::OP_NONE;
        cmd.flag_idx = flag_reg;
        cmd.axis = axis_reg;
        case (state_reg)
            S_ANGLE:  cmd.op = fco_pkg::OP_ANGLE;
            S_WRAP:   cmd.op = fco_pkg::OP_YAW_WRAP;
            S_YSTART: cmd.op = fco_pkg::OP_TRIG_YAW_START;
            S_YRUN:   cmd.op = fco_pkg::OP_TRIG_STEP;
            S_YDONE:  cmd.op = fco_pkg::OP_TRIG_YAW_DONE;
            S_PSTART: cmd.op = fco_pkg::OP_TRIG_PITCH_START;
            S_PRUN:   cmd.op = fco_pkg::OP_TRIG_STEP;
            S_PDONE:  cmd.op = fco_pkg::OP_TRIG_PITCH_DONE;
            S_FRONT:  cmd.op = fco_pkg::OP_FRONT;
            S_MOVE:   cmd.op = move_hit ? fco_pkg::OP_MOVE : fco_pkg::OP_NONE;
            S_VIEW:   cmd.op = fco_pkg::OP_VIEW;
            default:  cmd.op = fco_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            flag_reg <= '0;
            axis_reg <= '0;
            flags_reg <= '0;
            type_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        type_reg <= in_type;
                        flags_reg <= in_flags;
                        state_reg <= S_ANGLE;
                    end
                end
                S_ANGLE:  state_reg <= S_WRAP;
                S_WRAP:   if (wrap_last) state_reg <= S_YSTART;
                S_YSTART: state_reg <= S_YRUN;
                S_YRUN:   if (trig_last) state_reg <= S_YDONE;
                S_YDONE:  state_reg <= S_PSTART;
                S_PSTART: state_reg <= S_PRUN;
                S_PRUN:   if (trig_last) state_reg <= S_PDONE;
                S_PDONE:
                begin
                    axis_reg <= 2'd0;
                    state_reg <= S_FRONT;
                end
                S_FRONT:
                begin
                    if (axis_reg == 2'd0)
                        axis_reg <= 2'd2;
                    else
                    begin
                        axis_reg <= 2'd0;
                        flag_reg <= 3'd0;
                        state_reg <= (type_reg == fco_pkg::REQ_MOVE) ? S_MOVE : S_VIEW;
                    end
                end
                S_MOVE:
                begin
                    // skip axes a flag does not touch
                    if (!flags_reg[flag_reg] || axis_reg == 2'd2 ||
                        (flag_reg[2] && axis_reg == 2'd1) ||
                        (flag_reg[2:1] == 2'b01 && axis_reg == 2'd0 && 1'b0))
                    begin
                        axis_reg <= 2'd0;
                        if (flag_reg == 3'd5)
                            state_reg <= S_VIEW;
                        else
                            flag_reg <= flag_reg + 3'd1;
                        if (flags_reg[flag_reg] && flag_reg[2] && axis_reg == 2'd1)
                            axis_reg <= 2'd0;
                    end
                    else if (flag_reg[2])
                        axis_reg <= 2'd1;
                    else if (flag_reg[1] && axis_reg == 2'd0)
                        axis_reg <= 2'd2;
                    else
                        axis_reg <= axis_reg + 2'd1;
                end
                S_VIEW:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

>>> rtl/core/fly_camera_orientation_unit.sv
// Top level of the fly camera orientation unit: config registers, control, datapath.
// Depends on fco_pkg, fco_control and fco_datapath.
// Each request runs an eight-step yaw wrap and then the shared CORDIC unit, one iteration
// per cycle, for yaw and then pitch; a move request also steps through the six move flags
// and each axis that a set flag moves. One request is in flight at a time; the result
// stays on the outputs until taken, and the next request is accepted from the cycle after.
`default_nettype none
module fly_camera_orientation_unit #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int TRIG_ITERATIONS = 14
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 req_type,
    input  wire logic signed [15:0]   turn_dx,
    input  wire logic signed [15:0]   turn_dy,
    input  wire logic [5:0]           move_flags,
    input  wire logic [15:0]          time_delta,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        view_x,
    output logic signed [31:0]        view_y,
    output logic signed [31:0]        view_z,
    output logic signed [15:0]        front_x,
    output logic signed [15:0]        front_y,
    output logic signed [15:0]        front_z,
    output logic [15:0]               yaw_out,
    output logic signed [14:0]        pitch_out
);
    logic [9:0] sens_reg;
    logic [15:0] speed_reg;
    logic signed [31:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic busy, trig_last, wrap_last, in_fire, out_fire;
    logic type_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [15:0] delta_reg;
    fco_pkg::cmd_t cmd;

    assign in_ready = !busy;
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg <= 10'd102;
            speed_reg <= 16'd640;
            eye_x_reg <= '0;
            eye_y_reg <= '0;
            eye_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fco_pkg::CFG_SENS:  sens_reg <= cfg_data[9:0];
                fco_pkg::CFG_SPEED: speed_reg <= cfg_data[15:0];
                fco_pkg::CFG_EYE_X: eye_x_reg <= cfg_data;
                fco_pkg::CFG_EYE_Y: eye_y_reg <= cfg_data;
                fco_pkg::CFG_EYE_Z: eye_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            type_reg <= req_type;
            dx_reg <= turn_dx;
            dy_reg <= turn_dy;
            delta_reg <= time_delta;
        end
    end

    fco_control u_control (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_type(req_type),
        .in_flags(move_flags), .trig_last(trig_last), .wrap_last(wrap_last),
        .out_fire(out_fire), .busy(busy), .out_valid(out_valid), .cmd(cmd)
    );

    fco_datapath #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_datapath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_type(type_reg),
        .in_dx(dx_reg), .in_dy(dy_reg), .in_delta(delta_reg),
        .sens(sens_reg), .speed(speed_reg),
        .eye_x(eye_x_reg), .eye_y(eye_y_reg), .eye_z(eye_z_reg),
        .trig_last(trig_last), .wrap_last(wrap_last),
        .view_x(view_x), .view_y(view_y), .view_z(view_z),
        .front_x(front_x), .front_y(front_y), .front_z(front_z),
        .yaw_out(yaw_out), .pitch_out(pitch_out)
    );
endmodule
`default_nettype wire

>>> rtl/core/fco_checker.sv
// Port-level checks for the fly camera orientation unit.
// Depends on fly_camera_orientation_unit.
`default_nettype none
module fco_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [15:0] yaw_out,
    input wire logic signed [14:0] pitch_out
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("request taken while result pending");
    a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid) else $error("no busy after request");
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> yaw_out < 16'd46080) else $error("yaw out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pitch_out))
        else $error("result dropped");
endmodule

bind fly_camera_orientation_unit fco_checker u_fco_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .yaw_out(yaw_out), .pitch_out(pitch_out)
);
`default_nettype wire
